### hw/rtl/etc_pkg.sv
// Shared types and constants for the encoder tachometer channel.
// No dependencies; every other file in this block imports it.
package etc_pkg;

  localparam int LOG2_WINDOW_DEF = 3;
  localparam int TIMER_BITS_DEF  = 16;

  localparam int STAMP_IN_W = 16;
  localparam int PERIOD_W   = 18;
  localparam int ROLL_W     = 4;
  localparam int STEP_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [PERIOD_W-1:0] STOP_PERIOD = 18'h20000;
  localparam logic [ROLL_W-1:0]   ROLL_MAX    = 4'd15;

  localparam logic [ROLL_W-1:0] ROLL_LIMIT_RST  = 4'd2;
  localparam logic [ROLL_W-1:0] STALL_LIMIT_RST = 4'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_LIMIT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 4'd1;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] DIR_STOPPED = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  typedef struct packed {
    logic                  cmd;
    logic [STAMP_IN_W-1:0] capture_time;
    logic                  enc_b;
  } item_t;

  typedef struct packed {
    logic [1:0]               direction;
    logic [PERIOD_W-1:0]      period_avg;
    logic signed [STEP_W-1:0] step_count;
  } result_t;

  // One measured period handed to the averaging window.
  typedef struct packed {
    logic                push;
    logic [PERIOD_W-1:0] period;
  } push_t;

endpackage

### hw/rtl/etc_measure.sv
// Edge and rollover bookkeeping: step count, direction, period measurement.
// Depends on etc_pkg.
module etc_measure #(
  parameter int TIMER_BITS = etc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  etc_pkg::item_t                item,
  input  logic [etc_pkg::ROLL_W-1:0]    roll_limit,
  input  logic [etc_pkg::ROLL_W-1:0]    stall_limit,
  output etc_pkg::push_t                push,
  output logic [1:0]                    direction,
  output logic signed [etc_pkg::STEP_W-1:0] step_count
);
  import etc_pkg::*;

  localparam int STAMP_W = (TIMER_BITS < STAMP_IN_W) ? TIMER_BITS : STAMP_IN_W;
  localparam int NOW_W   = TIMER_BITS + ROLL_W;
  localparam int DIFF_W  = ((NOW_W > PERIOD_W) ? NOW_W : PERIOD_W) + 1;

  logic [STAMP_W-1:0] prev_stamp, prev_stamp_next;
  logic [ROLL_W-1:0]  rollover_count, rollover_count_next;
  logic [STEP_W-1:0]  net_steps, net_steps_next;
  logic [1:0]         dir_state, dir_state_next;

  logic [STAMP_W-1:0]  stamp;
  logic [NOW_W-1:0]    now_time;
  logic [DIFF_W-1:0]   diff;
  logic [PERIOD_W-1:0] measured;

  assign stamp    = item.capture_time[STAMP_W-1:0];
  assign now_time = (NOW_W'(rollover_count) << TIMER_BITS) | NOW_W'(stamp);
  assign diff     = DIFF_W'(now_time) - DIFF_W'(prev_stamp);

  // The sign bit of the widened difference flags a stamp earlier than the last one.
  always_comb begin
    if (diff[DIFF_W-1]) begin
      measured = '0;
    end else if (diff > DIFF_W'(STOP_PERIOD)) begin
      measured = STOP_PERIOD;
    end else begin
      measured = diff[PERIOD_W-1:0];
    end
  end

  always_comb begin
    prev_stamp_next     = prev_stamp;
    rollover_count_next = rollover_count;
    net_steps_next      = net_steps;
    dir_state_next      = dir_state;
    push                = '0;
    if (item.cmd == CMD_EDGE) begin
      if (item.enc_b) begin
        net_steps_next = net_steps + STEP_W'(1);
        dir_state_next = DIR_FORWARD;
      end else begin
        net_steps_next = net_steps - STEP_W'(1);
        dir_state_next = DIR_REVERSE;
      end
      push.push = 1'b1;
      if (rollover_count < roll_limit) begin
        push.period = measured;
      end else begin
        dir_state_next = DIR_STOPPED;
        push.period    = STOP_PERIOD;
      end
      prev_stamp_next     = stamp;
      rollover_count_next = '0;
    end else begin
      if (rollover_count < ROLL_MAX) begin
        rollover_count_next = rollover_count + ROLL_W'(1);
      end
      if (rollover_count_next > stall_limit) begin
        dir_state_next = DIR_STOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp     <= '0;
      rollover_count <= '0;
      net_steps      <= '0;
      dir_state      <= DIR_STOPPED;
    end else if (fire) begin
      prev_stamp     <= prev_stamp_next;
      rollover_count <= rollover_count_next;
      net_steps      <= net_steps_next;
      dir_state      <= dir_state_next;
    end
  end

  assign direction  = dir_state_next;
  assign step_count = signed'(net_steps_next);

endmodule

### hw/rtl/etc_history.sv
// Moving average window over the last measured periods, held in a small memory.
// Depends on etc_pkg.
module etc_history #(
  parameter int LOG2_WINDOW = etc_pkg::LOG2_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  etc_pkg::push_t                push,
  output logic [etc_pkg::PERIOD_W-1:0]  period_avg
);
  import etc_pkg::*;

  localparam int DEPTH = 1 << LOG2_WINDOW;
  localparam int SUM_W = PERIOD_W + LOG2_WINDOW;

  logic [PERIOD_W-1:0]    mem [DEPTH];
  logic [DEPTH-1:0]       written;
  logic [LOG2_WINDOW-1:0] index, index_next;
  logic [PERIOD_W-1:0]    oldest_q;
  logic                   oldest_valid_q;
  logic [SUM_W-1:0]       sum, sum_next;
  logic [PERIOD_W-1:0]    avg_reg, avg_next;
  logic                   do_push;
  logic [PERIOD_W-1:0]    oldest;

  assign do_push    = fire && push.push;
  assign index_next = do_push ? index + LOG2_WINDOW'(1) : index;
  // An entry never written since reset counts as zero.
  assign oldest     = oldest_valid_q ? oldest_q : '0;
  assign sum_next   = sum - SUM_W'(oldest) + SUM_W'(push.period);
  assign avg_next   = PERIOD_W'(sum_next >> LOG2_WINDOW);
  assign period_avg = do_push ? avg_next : avg_reg;

  // The read always looks one slot ahead, so the entry about to be replaced
  // is already registered when the next period arrives.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[index] <= push.period;
    end
    oldest_q <= mem[index_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written        <= '0;
      oldest_valid_q <= 1'b0;
      index          <= '0;
      sum            <= '0;
      avg_reg        <= STOP_PERIOD;
    end else begin
      oldest_valid_q <= written[index_next];
      if (do_push) begin
        written[index] <= 1'b1;
        index          <= index_next;
        sum            <= sum_next;
        avg_reg        <= avg_next;
      end
    end
  end

endmodule

### hw/rtl/encoder_tachometer_channel.sv
// One wheel channel of an encoder tachometer: edges and rollover ticks in,
// direction, averaged period and step count out. Depends on etc_pkg,
// etc_measure and etc_history.
//
// Every word in gives exactly one result word. A word is registered on
// acceptance, updated through combinational logic (step count, period
// measurement, window average) and lands in the result register. A new
// word is taken every cycle while the result side keeps up. The averaging
// window sits in a memory with one valid flag per entry cleared at reset,
// so no clearing pass is needed. Configuration writes are always taken and
// must only be issued while the channel is idle.
module encoder_tachometer_channel #(
  parameter int LOG2_WINDOW = etc_pkg::LOG2_WINDOW_DEF,
  parameter int TIMER_BITS  = etc_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  etc_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output etc_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [etc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import etc_pkg::*;

  logic [ROLL_W-1:0] roll_limit;
  logic [ROLL_W-1:0] stall_limit;

  item_t item_q;
  logic  item_q_valid;
  logic  advance;
  logic  fire;

  push_t                    push;
  logic [1:0]               direction;
  logic signed [STEP_W-1:0] step_count;
  logic [PERIOD_W-1:0]      period_avg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_limit  <= ROLL_LIMIT_RST;
      stall_limit <= STALL_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROLL_LIMIT:  roll_limit  <= cfg_data;
        CFG_STALL_LIMIT: stall_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance    = !result_valid || result_ready;
  assign item_ready = !item_q_valid || advance;
  assign fire       = item_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        item_q_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= item_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    if (fire) begin
      result.direction  <= direction;
      result.period_avg <= period_avg;
      result.step_count <= step_count;
    end
  end

  etc_measure #(
    .TIMER_BITS(TIMER_BITS)
  ) u_measure (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (item_q),
    .roll_limit (roll_limit),
    .stall_limit(stall_limit),
    .push       (push),
    .direction  (direction),
    .step_count (step_count)
  );

  etc_history #(
    .LOG2_WINDOW(LOG2_WINDOW)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .push      (push),
    .period_avg(period_avg)
  );

endmodule
